>>> src/ipv4_packet_statistics_assert.svh
// Assertion macros shared by the statistics block.
`ifndef IPV4_PACKET_STATISTICS_ASSERT_SVH
`define IPV4_PACKET_STATISTICS_ASSERT_SVH

// Checked at every clock edge outside reset.
`define IPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define IPS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> src/ips_pkg.sv
// Types, constants and helper functions of the IPv4 statistics block.
`default_nettype none
package ips_pkg;
    localparam int unsigned DEF_ADDRESS_ENTRIES = 64;
    localparam int unsigned DEF_PAIR_ENTRIES    = 64;
    localparam int unsigned DEF_MAX_FRAME       = 16384;

    localparam logic [14:0] MIN_FRAME_RESET = 15'd46;
    localparam logic [15:0] ETH_IPV4        = 16'h0800;
    localparam int unsigned DF_POS          = 14;
    localparam int unsigned MF_POS          = 13;
    localparam logic [15:0] OFF_MASK        = 16'h1FFF;
    // Frame lengths are compared at this width so that MAX_FRAME fits.
    localparam int unsigned FLEN_CMP_W      = 17;

    localparam logic [2:0] CLASS_ICMP  = 3'd0;
    localparam logic [2:0] CLASS_IGMP  = 3'd1;
    localparam logic [2:0] CLASS_IPIP  = 3'd2;
    localparam logic [2:0] CLASS_TCP   = 3'd3;
    localparam logic [2:0] CLASS_UDP   = 3'd4;
    localparam logic [2:0] CLASS_IPV6  = 3'd5;
    localparam logic [2:0] CLASS_OSPF  = 3'd6;
    localparam logic [2:0] CLASS_OTHER = 3'd7;

    localparam logic [1:0] FRAG_NONE   = 2'd0;
    localparam logic [1:0] FRAG_FIRST  = 2'd1;
    localparam logic [1:0] FRAG_MIDDLE = 2'd2;
    localparam logic [1:0] FRAG_LAST   = 2'd3;

    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] rx;
        logic [31:0] tx;
    } t_addr_entry;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [31:0] count;
    } t_pair_entry;

    function automatic logic [2:0] proto_class_of(input logic [7:0] proto);
        logic [2:0] c;
        case (proto)
            8'd1:    c = CLASS_ICMP;
            8'd2:    c = CLASS_IGMP;
            8'd4:    c = CLASS_IPIP;
            8'd6:    c = CLASS_TCP;
            8'd17:   c = CLASS_UDP;
            8'd41:   c = CLASS_IPV6;
            8'd89:   c = CLASS_OSPF;
            default: c = CLASS_OTHER;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] size_bin_of(input logic [15:0] len);
        logic [2:0] b;
        if (len <= 16'd159)       b = 3'd0;
        else if (len <= 16'd639)  b = 3'd1;
        else if (len <= 16'd1279) b = 3'd2;
        else if (len <= 16'd5119) b = 3'd3;
        else                      b = 3'd4;
        return b;
    endfunction
endpackage
`default_nettype wire

>>> src/ipv4_packet_statistics.sv
// Top level of the IPv4 header statistics block with its address and pair tables.
//
// Input channel: i_valid/o_ready carry the header fields of one frame; output channel
// o_valid/i_ready carry one result per frame. i_cfg_we writes min_frame_len at once.
// A frame is taken only while the block is idle. A frame that is short or not IPv4
// goes straight to the output state, and the next frame can be taken only once the
// block is back in idle. An IPv4 frame scans both tables together through one read
// port of each memory, one entry per cycle, up to the larger fill count of the two
// tables (at most ADDRESS_ENTRIES or PAIR_ENTRIES). The scan leads into the states
// S_UPD_SRC, which writes back the source entry and the pair entry, and S_UPD_DST,
// which writes back the destination entry and is skipped when source and destination
// are equal, then into the output state, which returns to idle as it offers the result.
// The result sits in an output register until it is taken. While the receiver stalls,
// the block still takes one more frame and works it through, then holds in its final
// state, taking no frame, until the waiting result is taken.
// Reset clears the frame counter, the fill counts of both tables (so every entry
// reads as free, no clearing pass is needed) and min_frame_len to 46.
// New entries fill the tables from slot 0 upward and are never freed, so an entry
// is in use exactly when its index lies below the table's fill count.
`default_nettype none
`include "ipv4_packet_statistics_assert.svh"
module ipv4_packet_statistics
    import ips_pkg::*;
#(
    parameter int unsigned ADDRESS_ENTRIES = DEF_ADDRESS_ENTRIES,
    parameter int unsigned PAIR_ENTRIES    = DEF_PAIR_ENTRIES,
    parameter int unsigned MAX_FRAME       = DEF_MAX_FRAME
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [14:0]        i_cfg_wdata,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [14:0]        i_frame_len,
    input  wire logic [15:0]        i_ether_type,
    input  wire logic [3:0]         i_header_words,
    input  wire logic [15:0]        i_total_len,
    input  wire logic [7:0]         i_protocol,
    input  wire logic [15:0]        i_frag_field,
    input  wire logic [31:0]        i_src_addr,
    input  wire logic [31:0]        i_dst_addr,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic                    o_is_ipv4,
    output logic [31:0]             o_packet_number,
    output logic [5:0]              o_header_bytes,
    output logic signed [16:0]      o_payload_len,
    output logic [2:0]              o_proto_class,
    output logic [2:0]              o_size_bin,
    output logic [1:0]              o_frag_kind,
    output logic [15:0]             o_first_byte,
    output logic signed [17:0]      o_last_byte,
    output logic [31:0]             o_src_tx_count,
    output logic [31:0]             o_dst_rx_count,
    output logic [31:0]             o_pair_count
);
    localparam int unsigned AAW = $clog2(ADDRESS_ENTRIES);
    localparam int unsigned ACW = $clog2(ADDRESS_ENTRIES + 1);
    localparam int unsigned PAW = $clog2(PAIR_ENTRIES);
    localparam int unsigned PCW = $clog2(PAIR_ENTRIES + 1);
    localparam int unsigned SW  = (ACW > PCW) ? ACW : PCW;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_UPD_SRC = 3'd2;
    localparam logic [2:0] S_UPD_DST = 3'd3;
    localparam logic [2:0] S_OUT     = 3'd4;

    t_addr_entry a_mem [ADDRESS_ENTRIES];
    t_pair_entry p_mem [PAIR_ENTRIES];

    logic [2:0]         r_state;
    logic [14:0]        r_min_len;
    logic [31:0]        r_frames;
    logic [ACW-1:0]     r_afill;
    logic [PCW-1:0]     r_pfill;

    // Fields of the frame at work.
    logic               r_is_ipv4;
    logic [31:0]        r_pkt_num;
    logic [5:0]         r_hbytes;
    logic signed [16:0] r_payload;
    logic [2:0]         r_class;
    logic [2:0]         r_bin;
    logic [1:0]         r_kind;
    logic [15:0]        r_first;
    logic [31:0]        r_src;
    logic [31:0]        r_dst;

    // Scan state.
    logic [SW-1:0]      r_idx;
    logic [SW-1:0]      r_lim;
    logic               r_rd_vld;
    logic [SW-1:0]      r_rd_idx;
    t_addr_entry        r_a_rd;
    t_pair_entry        r_p_rd;
    logic               r_src_hit;
    logic [AAW-1:0]     r_src_slot;
    t_addr_entry        r_src_ent;
    logic               r_dst_hit;
    logic [AAW-1:0]     r_dst_slot;
    t_addr_entry        r_dst_ent;
    logic               r_pair_hit;
    logic [PAW-1:0]     r_pair_slot;
    t_pair_entry        r_pair_ent;

    logic [31:0]        r_src_cnt;
    logic [31:0]        r_dst_cnt;
    logic [31:0]        r_pair_cnt;

    logic               a_we;
    logic [AAW-1:0]     a_waddr;
    t_addr_entry        a_wdata;
    logic               p_we;
    logic [PAW-1:0]     p_waddr;
    t_pair_entry        p_wdata;

    logic               in_xfer;
    logic               same_addr;
    logic               a_room;
    logic               p_room;
    logic [FLEN_CMP_W-1:0] n_flen;
    logic               n_is_ipv4;
    logic [15:0]        n_offset;
    logic               n_df;
    logic               n_mf;
    logic [5:0]         n_hbytes;
    logic signed [17:0] n_last;
    logic               rd_in_a;
    logic               rd_in_p;

    assign o_ready   = (r_state == S_IDLE);
    assign in_xfer   = i_valid && o_ready;
    assign same_addr = (r_src == r_dst);
    assign a_room    = (r_afill < ACW'(ADDRESS_ENTRIES));
    assign p_room    = (r_pfill < PCW'(PAIR_ENTRIES));
    assign rd_in_a   = r_rd_vld && (r_rd_idx < SW'(r_afill));
    assign rd_in_p   = r_rd_vld && (r_rd_idx < SW'(r_pfill));

    always_comb begin
        n_flen = {2'b00, i_frame_len};
        if (n_flen > FLEN_CMP_W'(MAX_FRAME)) begin
            n_flen = FLEN_CMP_W'(MAX_FRAME);
        end
        n_is_ipv4 = (n_flen >= {2'b00, r_min_len}) && (i_ether_type == ETH_IPV4);
        n_offset  = i_frag_field & OFF_MASK;
        n_df      = i_frag_field[DF_POS];
        n_mf      = i_frag_field[MF_POS];
        n_hbytes  = {i_header_words, 2'b00};
        n_last    = 18'($signed({2'b00, r_first})) + 18'(r_payload) - 18'sd1;
    end

    // Write-back to the tables.
    always_comb begin
        a_we    = 1'b0;
        a_waddr = r_src_slot;
        a_wdata = r_src_ent;
        p_we    = 1'b0;
        p_waddr = r_pair_slot;
        p_wdata = r_pair_ent;
        case (r_state)
            S_UPD_SRC: begin
                if (r_src_hit) begin
                    a_we    = 1'b1;
                    a_waddr = r_src_slot;
                    a_wdata = r_src_ent;
                    a_wdata.tx = r_src_ent.tx + 32'd1;
                    if (same_addr) begin
                        a_wdata.rx = r_src_ent.rx + 32'd1;
                    end
                end else if (a_room) begin
                    a_we    = 1'b1;
                    a_waddr = r_afill[AAW-1:0];
                    a_wdata.addr = r_src;
                    a_wdata.tx   = 32'd1;
                    a_wdata.rx   = same_addr ? 32'd1 : 32'd0;
                end
                if (r_pair_hit) begin
                    p_we    = 1'b1;
                    p_waddr = r_pair_slot;
                    p_wdata = r_pair_ent;
                    p_wdata.count = r_pair_ent.count + 32'd1;
                end else if (p_room) begin
                    p_we    = 1'b1;
                    p_waddr = r_pfill[PAW-1:0];
                    p_wdata.src   = r_src;
                    p_wdata.dst   = r_dst;
                    p_wdata.count = 32'd1;
                end
            end
            S_UPD_DST: begin
                if (r_dst_hit) begin
                    a_we    = 1'b1;
                    a_waddr = r_dst_slot;
                    a_wdata = r_dst_ent;
                    a_wdata.rx = r_dst_ent.rx + 32'd1;
                end else if (a_room) begin
                    a_we    = 1'b1;
                    a_waddr = r_afill[AAW-1:0];
                    a_wdata.addr = r_dst;
                    a_wdata.tx   = 32'd0;
                    a_wdata.rx   = 32'd1;
                end
            end
            default: begin
                a_we = 1'b0;
                p_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (a_we) begin
            a_mem[a_waddr] <= a_wdata;
        end
        if (p_we) begin
            p_mem[p_waddr] <= p_wdata;
        end
        r_a_rd <= a_mem[r_idx[AAW-1:0]];
        r_p_rd <= p_mem[r_idx[PAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_min_len <= MIN_FRAME_RESET;
            r_frames  <= '0;
            r_afill   <= '0;
            r_pfill   <= '0;
            r_rd_vld  <= 1'b0;
            o_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_min_len <= i_cfg_wdata;
            end
            // A new result handed over in the same cycle keeps o_valid high.
            if (o_valid && i_ready && r_state != S_OUT) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_frames  <= r_frames + 32'd1;
                        r_pkt_num <= r_frames + 32'd1;
                        r_is_ipv4 <= n_is_ipv4;
                        r_hbytes  <= n_hbytes;
                        r_payload <= $signed({1'b0, i_total_len}) -
                                     $signed({11'b0, n_hbytes});
                        r_class   <= proto_class_of(i_protocol);
                        r_bin     <= size_bin_of(i_total_len);
                        if (n_df || (!n_mf && n_offset == 16'd0)) begin
                            r_kind  <= FRAG_NONE;
                            r_first <= 16'd0;
                        end else if (n_offset == 16'd0) begin
                            r_kind  <= FRAG_FIRST;
                            r_first <= 16'd0;
                        end else begin
                            r_kind  <= n_mf ? FRAG_MIDDLE : FRAG_LAST;
                            r_first <= {n_offset[12:0], 3'b000};
                        end
                        r_src       <= i_src_addr;
                        r_dst       <= i_dst_addr;
                        r_src_hit   <= 1'b0;
                        r_dst_hit   <= 1'b0;
                        r_pair_hit  <= 1'b0;
                        r_src_cnt   <= '0;
                        r_dst_cnt   <= '0;
                        r_pair_cnt  <= '0;
                        r_idx       <= '0;
                        r_rd_vld    <= 1'b0;
                        r_lim       <= (SW'(r_afill) > SW'(r_pfill)) ?
                                       SW'(r_afill) : SW'(r_pfill);
                        r_state     <= n_is_ipv4 ? S_SCAN : S_OUT;
                    end
                end
                S_SCAN: begin
                    // Reads go out one per cycle; each compare sees the data
                    // of the read issued in the previous cycle.
                    if (r_idx < r_lim) begin
                        r_rd_vld <= 1'b1;
                        r_rd_idx <= r_idx;
                        r_idx    <= r_idx + SW'(1);
                    end else begin
                        r_rd_vld <= 1'b0;
                        if (!r_rd_vld) begin
                            r_state <= S_UPD_SRC;
                        end
                    end
                    if (rd_in_a && !r_src_hit && r_a_rd.addr == r_src) begin
                        r_src_hit  <= 1'b1;
                        r_src_slot <= r_rd_idx[AAW-1:0];
                        r_src_ent  <= r_a_rd;
                    end
                    if (rd_in_a && !r_dst_hit && r_a_rd.addr == r_dst) begin
                        r_dst_hit  <= 1'b1;
                        r_dst_slot <= r_rd_idx[AAW-1:0];
                        r_dst_ent  <= r_a_rd;
                    end
                    if (rd_in_p && !r_pair_hit && r_p_rd.src == r_src &&
                        r_p_rd.dst == r_dst) begin
                        r_pair_hit  <= 1'b1;
                        r_pair_slot <= r_rd_idx[PAW-1:0];
                        r_pair_ent  <= r_p_rd;
                    end
                end
                S_UPD_SRC: begin
                    if (r_src_hit || a_room) begin
                        r_src_cnt <= a_wdata.tx;
                        if (same_addr) begin
                            r_dst_cnt <= a_wdata.rx;
                        end
                        if (!r_src_hit) begin
                            r_afill <= r_afill + ACW'(1);
                        end
                    end
                    if (r_pair_hit || p_room) begin
                        r_pair_cnt <= p_wdata.count;
                        if (!r_pair_hit) begin
                            r_pfill <= r_pfill + PCW'(1);
                        end
                    end
                    r_state <= same_addr ? S_OUT : S_UPD_DST;
                end
                S_UPD_DST: begin
                    if (r_dst_hit || a_room) begin
                        r_dst_cnt <= a_wdata.rx;
                        if (!r_dst_hit) begin
                            r_afill <= r_afill + ACW'(1);
                        end
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!o_valid || i_ready) begin
                        o_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result register; loaded when the result is handed over.
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!o_valid || i_ready)) begin
            o_is_ipv4       <= r_is_ipv4;
            o_packet_number <= r_pkt_num;
            o_header_bytes  <= r_is_ipv4 ? r_hbytes : '0;
            o_payload_len   <= r_is_ipv4 ? r_payload : '0;
            o_proto_class   <= r_is_ipv4 ? r_class : '0;
            o_size_bin      <= r_is_ipv4 ? r_bin : '0;
            o_frag_kind     <= r_is_ipv4 ? r_kind : '0;
            o_first_byte    <= r_is_ipv4 ? r_first : '0;
            o_last_byte     <= r_is_ipv4 ? n_last : '0;
            o_src_tx_count  <= r_src_cnt;
            o_dst_rx_count  <= r_dst_cnt;
            o_pair_count    <= r_pair_cnt;
        end
    end

    `IPS_ASSERT(a_afill_bound, r_afill <= ACW'(ADDRESS_ENTRIES), "address fill overflow")
    `IPS_ASSERT(a_pfill_bound, r_pfill <= PCW'(PAIR_ENTRIES), "pair fill overflow")
    `IPS_ASSERT(a_no_write_idle, (a_we || p_we) |-> (r_state != S_IDLE), "table write while idle")
    `IPS_ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n |=> !o_valid, "result valid after reset")
endmodule
`default_nettype wire

>>> sim/ipv4_packet_statistics_tb.sv
// Self-checking testbench for the IPv4 header statistics block.
`default_nettype none
module ipv4_packet_statistics_tb
    import ips_pkg::*;
;

    typedef struct packed {
        logic [14:0] frame_len;
        logic [15:0] ether_type;
        logic [3:0]  header_words;
        logic [15:0] total_len;
        logic [7:0]  protocol;
        logic [15:0] frag_field;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
    } t_frame;

    typedef struct packed {
        logic        is_ipv4;
        logic [31:0] packet_number;
        logic [5:0]  header_bytes;
        logic [16:0] payload_len;
        logic [2:0]  proto_class;
        logic [2:0]  size_bin;
        logic [1:0]  frag_kind;
        logic [15:0] first_byte;
        logic [17:0] last_byte;
        logic [31:0] src_tx_count;
        logic [31:0] dst_rx_count;
        logic [31:0] pair_count;
    } t_stats;

    typedef struct packed {
        t_frame f;
        logic   typed;
        t_stats r;
    } t_row;

    localparam int N_ADDR = DEF_ADDRESS_ENTRIES;
    localparam int N_PAIR = DEF_PAIR_ENTRIES;
    localparam int N_ROWS = 18;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [14:0] i_cfg_wdata = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    t_frame      drv = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    t_stats      got;

    ipv4_packet_statistics dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_frame_len(drv.frame_len), .i_ether_type(drv.ether_type),
        .i_header_words(drv.header_words), .i_total_len(drv.total_len),
        .i_protocol(drv.protocol), .i_frag_field(drv.frag_field),
        .i_src_addr(drv.src_addr), .i_dst_addr(drv.dst_addr),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_is_ipv4(got.is_ipv4), .o_packet_number(got.packet_number),
        .o_header_bytes(got.header_bytes), .o_payload_len(got.payload_len),
        .o_proto_class(got.proto_class), .o_size_bin(got.size_bin),
        .o_frag_kind(got.frag_kind), .o_first_byte(got.first_byte),
        .o_last_byte(got.last_byte), .o_src_tx_count(got.src_tx_count),
        .o_dst_rx_count(got.dst_rx_count), .o_pair_count(got.pair_count)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the block's counters and tables.
    logic [14:0] min_len = MIN_FRAME_RESET;
    logic [31:0] frames_seen = '0;
    logic [31:0] class_totals [7];
    logic [31:0] bin_totals [5];
    logic        addr_used [N_ADDR];
    logic [31:0] addr_key [N_ADDR];
    logic [31:0] addr_rx [N_ADDR];
    logic [31:0] addr_tx [N_ADDR];
    logic        pair_used [N_PAIR];
    logic [31:0] pair_src [N_PAIR];
    logic [31:0] pair_dst [N_PAIR];
    logic [31:0] pair_hits [N_PAIR];
    logic        tables_full = 1'b0;

    t_stats pending_stats [$];
    int     errors = 0;
    logic   quiet = 1'b0;
    logic [31:0] addr_pool [12];
    t_row   dir_rows [N_ROWS];

    // Finds or allocates the slot of an address; -1 when the table has no room.
    function automatic int addr_slot(input logic [31:0] a);
        int free_slot;
        free_slot = -1;
        for (int i = 0; i < N_ADDR; i++) begin
            if (addr_used[i]) begin
                if (addr_key[i] == a) return i;
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        if (free_slot < 0) begin
            tables_full = 1'b1;
            return -1;
        end
        addr_used[free_slot] = 1'b1;
        addr_key[free_slot]  = a;
        addr_rx[free_slot]   = '0;
        addr_tx[free_slot]   = '0;
        return free_slot;
    endfunction

    function automatic logic [31:0] pair_tally(input logic [31:0] s, input logic [31:0] d);
        int free_slot;
        free_slot = -1;
        for (int i = 0; i < N_PAIR; i++) begin
            if (pair_used[i]) begin
                if (pair_src[i] == s && pair_dst[i] == d) begin
                    pair_hits[i] += 1;
                    return pair_hits[i];
                end
            end else if (free_slot < 0) begin
                free_slot = i;
            end
        end
        if (free_slot < 0) begin
            tables_full = 1'b1;
            return '0;
        end
        pair_used[free_slot] = 1'b1;
        pair_src[free_slot]  = s;
        pair_dst[free_slot]  = d;
        pair_hits[free_slot] = 32'd1;
        return 32'd1;
    endfunction

    function automatic t_stats tally_frame(input t_frame f);
        t_stats r;
        int flen, hb, payload, last, slot;
        logic [12:0] offset;
        logic [15:0] first;
        logic [2:0] pc, bin;
        r = '0;
        frames_seen += 1;
        r.packet_number = frames_seen;
        flen = (f.frame_len > DEF_MAX_FRAME) ? DEF_MAX_FRAME : f.frame_len;
        if (flen < min_len || f.ether_type != ETH_IPV4) return r;
        hb = f.header_words * 4;
        payload = int'(f.total_len) - hb;
        case (f.protocol)
            8'd1:    pc = CLASS_ICMP;
            8'd2:    pc = CLASS_IGMP;
            8'd4:    pc = CLASS_IPIP;
            8'd6:    pc = CLASS_TCP;
            8'd17:   pc = CLASS_UDP;
            8'd41:   pc = CLASS_IPV6;
            8'd89:   pc = CLASS_OSPF;
            default: pc = CLASS_OTHER;
        endcase
        if (pc != CLASS_OTHER) class_totals[pc] += 1;
        if (f.total_len <= 159)       bin = 3'd0;
        else if (f.total_len <= 639)  bin = 3'd1;
        else if (f.total_len <= 1279) bin = 3'd2;
        else if (f.total_len <= 5119) bin = 3'd3;
        else                          bin = 3'd4;
        bin_totals[bin] += 1;
        offset = f.frag_field[12:0];
        first = '0;
        if (f.frag_field[DF_POS] || (!f.frag_field[MF_POS] && offset == 0)) begin
            r.frag_kind = FRAG_NONE;
        end else if (offset == 0) begin
            r.frag_kind = FRAG_FIRST;
        end else begin
            r.frag_kind = f.frag_field[MF_POS] ? FRAG_MIDDLE : FRAG_LAST;
            first = {offset, 3'b000};
        end
        last = int'(first) + payload - 1;
        r.is_ipv4      = 1'b1;
        r.header_bytes = hb[5:0];
        r.payload_len  = payload[16:0];
        r.proto_class  = pc;
        r.size_bin     = bin;
        r.first_byte   = first;
        r.last_byte    = last[17:0];
        slot = addr_slot(f.src_addr);
        if (slot >= 0) begin
            addr_tx[slot] += 1;
            r.src_tx_count = addr_tx[slot];
        end
        // A frame sent to itself counts on the same entry twice.
        slot = addr_slot(f.dst_addr);
        if (slot >= 0) begin
            addr_rx[slot] += 1;
            r.dst_rx_count = addr_rx[slot];
        end
        r.pair_count = pair_tally(f.src_addr, f.dst_addr);
        return r;
    endfunction

    function automatic logic [31:0] pick_addr();
        int p;
        p = $urandom_range(99);
        if (p < 75) return addr_pool[$urandom_range(11)];
        return $urandom;
    endfunction

    function automatic t_frame random_frame();
        t_frame f;
        int p;
        logic [7:0] known [7];
        known = '{8'd1, 8'd2, 8'd4, 8'd6, 8'd17, 8'd41, 8'd89};
        p = $urandom_range(99);
        if (p < 8)       f.frame_len = 15'($urandom_range(0, 45));
        else if (p < 15) f.frame_len = 15'($urandom_range(0, 32767));
        else if (p < 20) f.frame_len = 15'($urandom_range(16300, 16384));
        else             f.frame_len = 15'($urandom_range(46, 1518));
        f.ether_type = ($urandom_range(99) < 85) ? ETH_IPV4 : 16'($urandom);
        f.header_words = ($urandom_range(99) < 60) ? 4'd5 : 4'($urandom);
        p = $urandom_range(99);
        if (p < 30)      f.total_len = 16'($urandom_range(0, 200));
        else if (p < 60) f.total_len = 16'($urandom_range(150, 1500));
        else if (p < 80) f.total_len = 16'($urandom_range(1200, 6000));
        else             f.total_len = 16'($urandom);
        f.protocol = ($urandom_range(99) < 70) ? known[$urandom_range(6)] : 8'($urandom);
        p = $urandom_range(99);
        if (p < 40)      f.frag_field = '0;
        else if (p < 70) f.frag_field = {3'($urandom_range(7)), 13'd0};
        else             f.frag_field = 16'($urandom);
        f.src_addr = pick_addr();
        f.dst_addr = ($urandom_range(99) < 5) ? f.src_addr : pick_addr();
        return f;
    endfunction

    // Holds the frame on the bus until the block takes it.
    task automatic offer(input t_frame f);
        while (!quiet && $urandom_range(99) < 8) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        drv     <= f;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic set_min_len(input logic [14:0] v);
        i_valid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        min_len = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int count);
        t_frame f;
        for (int n = 0; n < count; n++) begin
            f = random_frame();
            offer(f);
            pending_stats.push_back(tally_frame(f));
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp,
                               input logic [31:0] act);
        if (exp !== act) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, exp, act);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (quiet) i_ready <= 1'b1;
        else       i_ready <= ($urandom_range(99) >= 8);
    end

    always @(posedge i_clk) begin
        t_stats e;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_stats.size() == 0) begin
                $display("%0t: unexpected result, packet %0d", $time, got.packet_number);
                errors++;
            end else begin
                e = pending_stats.pop_front();
                check_field("is_ipv4", e.is_ipv4, got.is_ipv4);
                check_field("packet_number", e.packet_number, got.packet_number);
                check_field("header_bytes", e.header_bytes, got.header_bytes);
                check_field("payload_len", e.payload_len, got.payload_len);
                check_field("proto_class", e.proto_class, got.proto_class);
                check_field("size_bin", e.size_bin, got.size_bin);
                check_field("frag_kind", e.frag_kind, got.frag_kind);
                check_field("first_byte", e.first_byte, got.first_byte);
                check_field("last_byte", e.last_byte, got.last_byte);
                check_field("src_tx_count", e.src_tx_count, got.src_tx_count);
                check_field("dst_rx_count", e.dst_rx_count, got.dst_rx_count);
                check_field("pair_count", e.pair_count, got.pair_count);
            end
        end
    end

    initial begin
        t_stats r;
        for (int i = 0; i < 7; i++) class_totals[i] = '0;
        for (int i = 0; i < 5; i++) bin_totals[i] = '0;
        for (int i = 0; i < N_ADDR; i++) addr_used[i] = 1'b0;
        for (int i = 0; i < N_PAIR; i++) pair_used[i] = 1'b0;
        for (int i = 0; i < 12; i++) addr_pool[i] = $urandom;

        // Columns: frame_len, ether_type, IHL, total_len, protocol, flags/offset, src, dst.
        dir_rows[0]  = '{'{15'd60, 16'h86DD, 4'd5, 16'd100, 8'd6, 16'h0, 32'h1, 32'h2},
                         1'b1, '{1'b0, 32'd1, 6'd0, 17'd0, 3'd0, 3'd0, 2'd0, 16'd0,
                                 18'd0, 32'd0, 32'd0, 32'd0}};
        dir_rows[1]  = '{'{15'd45, ETH_IPV4, 4'd5, 16'd100, 8'd6, 16'h0, 32'h1, 32'h2},
                         1'b1, '{1'b0, 32'd2, 6'd0, 17'd0, 3'd0, 3'd0, 2'd0, 16'd0,
                                 18'd0, 32'd0, 32'd0, 32'd0}};
        dir_rows[2]  = '{'{15'd64, ETH_IPV4, 4'd5, 16'd100, 8'd6, 16'h0, 32'h1, 32'h2},
                         1'b1, '{1'b1, 32'd3, 6'd20, 17'd80, CLASS_TCP, 3'd0, FRAG_NONE,
                                 16'd0, 18'd79, 32'd1, 32'd1, 32'd1}};
        dir_rows[3]  = '{'{15'd64, ETH_IPV4, 4'd5, 16'd100, 8'd6, 16'h0, 32'h1, 32'h2},
                         1'b0, '0};
        dir_rows[4]  = '{'{15'd0, ETH_IPV4, 4'd5, 16'd100, 8'd6, 16'h0, 32'h1, 32'h2},
                         1'b1, '{1'b0, 32'd5, 6'd0, 17'd0, 3'd0, 3'd0, 2'd0, 16'd0,
                                 18'd0, 32'd0, 32'd0, 32'd0}};
        dir_rows[5]  = '{'{15'h7FFF, ETH_IPV4, 4'd0, 16'hFFFF, 8'hFF, 16'hFFFF,
                           32'hFFFF_FFFF, 32'h0}, 1'b0, '0};
        dir_rows[6]  = '{'{15'd46, ETH_IPV4, 4'd15, 16'd0, 8'd1, 16'h0, 32'h2, 32'h1},
                         1'b0, '0};
        dir_rows[7]  = '{'{15'd100, ETH_IPV4, 4'd5, 16'd159, 8'd2, 16'h2000, 32'h3, 32'h4},
                         1'b0, '0};
        dir_rows[8]  = '{'{15'd100, ETH_IPV4, 4'd5, 16'd160, 8'd4, 16'h2005, 32'h3, 32'h4},
                         1'b0, '0};
        dir_rows[9]  = '{'{15'd100, ETH_IPV4, 4'd0, 16'hFFFF, 8'd17, 16'h1FFF, 32'h3, 32'h4},
                         1'b0, '0};
        dir_rows[10] = '{'{15'd100, ETH_IPV4, 4'd5, 16'd639, 8'd41, 16'h8000, 32'h5, 32'h6},
                          1'b0, '0};
        dir_rows[11] = '{'{15'd100, ETH_IPV4, 4'd5, 16'd640, 8'd89, 16'h6010, 32'h7, 32'h7},
                          1'b0, '0};
        dir_rows[12] = '{'{15'd16384, ETH_IPV4, 4'd6, 16'd1279, 8'd6, 16'h0040, 32'h7, 32'h7},
                          1'b0, '0};
        dir_rows[13] = '{'{15'd16385, ETH_IPV4, 4'd5, 16'd1280, 8'd0, 16'hA001, 32'h8, 32'h1},
                          1'b0, '0};
        dir_rows[14] = '{'{15'd1500, ETH_IPV4, 4'd5, 16'd5119, 8'd3, 16'h0, 32'h8, 32'h2},
                          1'b0, '0};
        dir_rows[15] = '{'{15'd1500, ETH_IPV4, 4'd5, 16'd5120, 8'd88, 16'h0, 32'h1, 32'h8},
                          1'b0, '0};
        dir_rows[16] = '{'{15'd1500, 16'h0801, 4'd5, 16'd5120, 8'd6, 16'h0, 32'h1, 32'h8},
                          1'b0, '0};
        dir_rows[17] = '{'{15'd1500, 16'hF7FF, 4'd5, 16'd5120, 8'd6, 16'h0, 32'h1, 32'h8},
                          1'b0, '0};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            offer(dir_rows[k].f);
            r = tally_frame(dir_rows[k].f);
            pending_stats.push_back(dir_rows[k].typed ? dir_rows[k].r : r);
        end

        set_min_len(15'd0);
        random_phase(250);
        set_min_len(15'd16384);
        random_phase(100);
        set_min_len(15'd46);
        quiet <= 1'b1;
        random_phase(150);
        quiet <= 1'b0;
        random_phase(100);
        set_min_len(15'($urandom_range(0, 1518)));
        random_phase(230);

        i_valid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (errors == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire
